// ===== design/mqttfh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mqttfh_pkg
// Shared widths, byte kind codes, phase codes and defaults for the fixed
// header deframer.
// ----------------------------------------------------------------------------
package mqttfh_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned TYPE_W   = 4;
    localparam int unsigned LEN_W    = 28;
    localparam int unsigned BUF_W    = 16;
    localparam int unsigned DROP_W   = 16;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned PHASE_W  = 2;
    localparam int unsigned DIGIT_W  = 3;
    localparam int unsigned GROUP_W  = 7;

    localparam int unsigned MAX_LENGTH_DIGITS_DEF = 4;
    localparam logic [BUF_W-1:0] BUFFER_BYTES_RST = 16'd512;

    localparam logic [KIND_W-1:0] KIND_TYPE      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LENGTH    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_KEPT      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DROPPED   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MALFORMED = 3'd4;

    localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_LENGTH = 2'd1;
    localparam logic [PHASE_W-1:0] PH_BODY   = 2'd2;

endpackage : mqttfh_pkg
`default_nettype wire

// ===== design/mqtt_fixed_header_deframer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mqtt_fixed_header_deframer
// Frames received link bytes into packets and reports one result per byte.
// ----------------------------------------------------------------------------
// One byte in, one result out, one byte per clock sustained while the output
// side does not stall. A byte is captured in an input register, classified
// against the framing state and lands in the output register, so a result
// passes the input register and then the output register; the shift-add of the
// length field and the body countdown fit between them. The output register
// drains while the next byte is classified, so a new byte is taken every
// cycle unless the output side stalls. buffer_bytes resets to 512 and is
// written through i_cfg_we/i_cfg_wdata; the user must write it only while the
// block holds no byte, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module mqtt_fixed_header_deframer #(
    parameter int unsigned MAX_LENGTH_DIGITS = mqttfh_pkg::MAX_LENGTH_DIGITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [mqttfh_pkg::BUF_W-1:0]      i_cfg_wdata,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [mqttfh_pkg::BYTE_W-1:0]     i_rx_byte,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [mqttfh_pkg::KIND_W-1:0]          o_byte_kind,
    output logic [mqttfh_pkg::BYTE_W-1:0]          o_data_byte,
    output logic [mqttfh_pkg::TYPE_W-1:0]          o_packet_type,
    output logic [mqttfh_pkg::LEN_W-1:0]           o_body_length,
    output logic                                   o_packet_fits,
    output logic                                   o_last_of_packet,
    output logic [mqttfh_pkg::DROP_W-1:0]          o_drop_total
);

    localparam int unsigned BYTE_W  = mqttfh_pkg::BYTE_W;
    localparam int unsigned TYPE_W  = mqttfh_pkg::TYPE_W;
    localparam int unsigned LEN_W   = mqttfh_pkg::LEN_W;
    localparam int unsigned BUF_W   = mqttfh_pkg::BUF_W;
    localparam int unsigned DROP_W  = mqttfh_pkg::DROP_W;
    localparam int unsigned KIND_W  = mqttfh_pkg::KIND_W;
    localparam int unsigned PHASE_W = mqttfh_pkg::PHASE_W;
    localparam int unsigned DIGIT_W = mqttfh_pkg::DIGIT_W;
    localparam int unsigned GROUP_W = mqttfh_pkg::GROUP_W;
    localparam int unsigned TOT_W   = LEN_W + 1;
    localparam logic [DIGIT_W-1:0] MAX_DIGITS = DIGIT_W'(MAX_LENGTH_DIGITS);

    // Configuration
    logic [BUF_W-1:0]   r_buffer_bytes;

    // Input stage
    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;

    // Framing state
    logic [PHASE_W-1:0] r_phase,        n_phase;
    logic [TYPE_W-1:0]  r_type,         n_type;
    logic [LEN_W-1:0]   r_len_accum,    n_len_accum;
    logic [DIGIT_W-1:0] r_len_digits,   n_len_digits;
    logic [LEN_W-1:0]   r_body_left,    n_body_left;
    logic               r_fits,         n_fits;
    logic [DROP_W-1:0]  r_drop_cnt,     n_drop_cnt;

    // Result stage
    logic               r_out_valid;
    logic [KIND_W-1:0]  r_kind,         n_kind;
    logic [BYTE_W-1:0]  r_data;
    logic [LEN_W-1:0]   r_len_out,      n_len_out;
    logic               r_fits_out,     n_fits_out;
    logic               r_last,         n_last;

    logic               in_accept;
    logic               advance;
    logic [LEN_W-1:0]   group_shifted;
    logic [TOT_W-1:0]   total_len;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign group_shifted = LEN_W'(r_in_byte[GROUP_W-1:0]) << (GROUP_W * r_len_digits[1:0]);

    always_comb begin
        n_phase      = r_phase;
        n_type       = r_type;
        n_len_accum  = r_len_accum;
        n_len_digits = r_len_digits;
        n_body_left  = r_body_left;
        n_fits       = r_fits;
        n_drop_cnt   = r_drop_cnt;
        n_kind       = mqttfh_pkg::KIND_TYPE;
        n_len_out    = '0;
        n_fits_out   = 1'b0;
        n_last       = 1'b0;
        total_len    = '0;
        unique case (r_phase)
            mqttfh_pkg::PH_LENGTH: begin
                n_len_accum  = r_len_accum + group_shifted;
                n_len_digits = r_len_digits + DIGIT_W'(1);
                n_kind       = mqttfh_pkg::KIND_LENGTH;
                n_len_out    = n_len_accum;
                total_len    = TOT_W'(1) + TOT_W'(n_len_digits) + TOT_W'(n_len_accum);
                if (!r_in_byte[BYTE_W-1]) begin
                    n_fits     = (total_len <= TOT_W'(r_buffer_bytes));
                    n_fits_out = n_fits;
                    if (!n_fits && (r_drop_cnt != {DROP_W{1'b1}})) begin
                        n_drop_cnt = r_drop_cnt + DROP_W'(1);
                    end
                    if (n_len_accum == '0) begin
                        n_last  = 1'b1;
                        n_phase = mqttfh_pkg::PH_IDLE;
                    end else begin
                        n_body_left = n_len_accum;
                        n_phase     = mqttfh_pkg::PH_BODY;
                    end
                end else if (n_len_digits >= MAX_DIGITS) begin
                    n_kind  = mqttfh_pkg::KIND_MALFORMED;
                    n_last  = 1'b1;
                    n_fits  = 1'b0;
                    n_phase = mqttfh_pkg::PH_IDLE;
                end
            end
            mqttfh_pkg::PH_BODY: begin
                n_kind      = r_fits ? mqttfh_pkg::KIND_KEPT : mqttfh_pkg::KIND_DROPPED;
                n_fits_out  = r_fits;
                n_len_out   = r_len_accum;
                n_body_left = r_body_left - LEN_W'(1);
                if (n_body_left == '0) begin
                    n_last  = 1'b1;
                    n_phase = mqttfh_pkg::PH_IDLE;
                end
            end
            default: begin
                n_type       = r_in_byte[BYTE_W-1 -: TYPE_W];
                n_len_accum  = '0;
                n_len_digits = '0;
                n_body_left  = '0;
                n_fits       = 1'b0;
                n_phase      = mqttfh_pkg::PH_LENGTH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_bytes <= mqttfh_pkg::BUFFER_BYTES_RST;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_phase        <= mqttfh_pkg::PH_IDLE;
            r_type         <= '0;
            r_len_accum    <= '0;
            r_len_digits   <= '0;
            r_body_left    <= '0;
            r_fits         <= 1'b0;
            r_drop_cnt     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_buffer_bytes <= i_cfg_wdata;
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_phase      <= n_phase;
                r_type       <= n_type;
                r_len_accum  <= n_len_accum;
                r_len_digits <= n_len_digits;
                r_body_left  <= n_body_left;
                r_fits       <= n_fits;
                r_drop_cnt   <= n_drop_cnt;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
        if (advance) begin
            r_kind     <= n_kind;
            r_data     <= r_in_byte;
            r_len_out  <= n_len_out;
            r_fits_out <= n_fits_out;
            r_last     <= n_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_byte_kind      = r_kind;
    assign o_data_byte      = r_data;
    assign o_packet_type    = r_type;
    assign o_body_length    = r_len_out;
    assign o_packet_fits    = r_fits_out;
    assign o_last_of_packet = r_last;
    assign o_drop_total     = r_drop_cnt;

    a_malformed_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind == mqttfh_pkg::KIND_MALFORMED)) |->
            (r_last && !r_fits_out))
        else $error("malformed length without end of packet");

    a_body_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == mqttfh_pkg::PH_BODY) |-> (r_body_left != '0))
        else $error("body phase with nothing left");

    a_drop_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_drop_cnt >= $past(r_drop_cnt)))
        else $error("drop counter decreased");

    a_stall_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a held byte");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("classified byte lost");

endmodule : mqtt_fixed_header_deframer
`default_nettype wire
